// File: hdl/spa_pkg.sv
package spa_pkg;

	// Table geometry
	localparam int MAX_TERMS = 32;
	localparam int EXP_WIDTH = 8;

	// Field widths
	localparam int COEF_W = 16;
	localparam int EXPO_W = 8;
	localparam int SUM_W  = COEF_W + 1;

	// Table index and fill count widths
	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);

	// Exponent bits kept on insert
	localparam logic [EXPO_W-1:0] EXP_MASK = (EXP_WIDTH >= EXPO_W) ? {EXPO_W{1'b1}} :
		EXPO_W'((64'd1 << EXP_WIDTH) - 64'd1);

	typedef enum logic [1:0] {
		OP_INS_A = 2'd0,
		OP_INS_B = 2'd1,
		OP_SUM   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t                      op;
		logic signed [COEF_W-1:0] coef;
		logic [EXPO_W-1:0]        exponent;
	} cmd_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum_coef;
		logic [EXPO_W-1:0]       sum_exponent;
		logic                    last;
		logic                    empty_res;
		logic                    overflow;
	} sum_t;

	// One stored term
	typedef struct packed {
		logic signed [COEF_W-1:0] coef;
		logic [EXPO_W-1:0]        expo;
	} term_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS,
		ST_LAST,
		ST_MERGE
	} state_t;

endpackage

// File: hdl/sparse_polynomial_adder_core.sv
// Channel | Dir | Word  | Handshake
// cmd     | in  | cmd_t | cmd_valid / cmd_stall, taken when valid high and stall low
// sum     | out | sum_t | sum_valid / sum_stall, taken when valid high and stall low
//
// Insert: an empty table takes the term directly, and a full table drops it and sets the
// overflow flag; otherwise the shift walks down the table from its tail to the landing slot
// through its single read port and single write port. Clear zeroes both fill counts. A sum
// starts from the head of each table, and the merge reads one head of each table per emitted
// word. Reset clears the fill counts and overflow flag; no clearing pass.
// A stalled sum word holds the merge; commands wait while any operation is in flight.
module sparse_polynomial_adder_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  spa_pkg::cmd_t cmd,
	output logic          sum_valid,
	input  logic          sum_stall,
	output spa_pkg::sum_t sum
);
	import spa_pkg::*;

	// Term tables: one synchronous read port and one write port each
	term_t mem_a [MAX_TERMS];
	term_t mem_b [MAX_TERMS];

	term_t rd_a, rd_b;
	logic [IDX_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
	logic we_a, we_b;
	term_t wr_data;

	// Control state
	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
	logic ovf_q, ovf_d;
	logic ins_b_q, ins_b_d;             // insert targets table B
	term_t new_q, new_d;                // term being inserted
	logic [IDX_W-1:0] rd_idx_q, rd_idx_d; // entry whose read data arrives this cycle
	logic [CNT_W-1:0] ia_q, ia_d, ib_q, ib_d; // merge heads

	// Output register
	logic sum_valid_q;
	sum_t sum_q, sum_d;
	logic sum_load;

	// Merge scratch
	term_t tgt_rd;
	logic [CNT_W-1:0] tgt_cnt;
	logic a_ok, b_ok, take_a, take_b;
	term_t cmd_term;

	assign sum_valid = sum_valid_q;
	assign sum       = sum_q;

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[wr_addr] <= wr_data;
		end
		if (we_b) begin
			mem_b[wr_addr] <= wr_data;
		end
		rd_a <= mem_a[rd_addr_a];
		rd_b <= mem_b[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ovf_q       <= 1'b0;
			sum_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_a_q <= cnt_a_d;
			cnt_b_q <= cnt_b_d;
			ovf_q   <= ovf_d;
			if (sum_load) begin
				sum_valid_q <= 1'b1;
			end else if (!sum_stall) begin
				sum_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		ins_b_q  <= ins_b_d;
		new_q    <= new_d;
		rd_idx_q <= rd_idx_d;
		ia_q     <= ia_d;
		ib_q     <= ib_d;
		if (sum_load) begin
			sum_q <= sum_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_a_d   = cnt_a_q;
		cnt_b_d   = cnt_b_q;
		ovf_d     = ovf_q;
		ins_b_d   = ins_b_q;
		new_d     = new_q;
		rd_idx_d  = rd_idx_q;
		ia_d      = ia_q;
		ib_d      = ib_q;
		rd_addr_a = '0;
		rd_addr_b = '0;
		we_a      = 1'b0;
		we_b      = 1'b0;
		wr_addr   = '0;
		wr_data   = new_q;
		sum_load  = 1'b0;
		sum_d     = '0;
		cmd_stall = (state_q != ST_IDLE);

		cmd_term.coef = cmd.coef;
		cmd_term.expo = cmd.exponent & EXP_MASK;
		tgt_rd  = ins_b_q ? rd_b : rd_a;
		tgt_cnt = ins_b_q ? cnt_b_q : cnt_a_q;
		a_ok    = (ia_q < cnt_a_q);
		b_ok    = (ib_q < cnt_b_q);
		take_a  = a_ok && (!b_ok || (rd_a.expo > rd_b.expo));
		take_b  = b_ok && (!a_ok || (rd_a.expo < rd_b.expo));

		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_INS_A, OP_INS_B: begin
							ins_b_d = (cmd.op == OP_INS_B);
							new_d   = cmd_term;
							wr_data = cmd_term;
							if (((cmd.op == OP_INS_B) ? cnt_b_q : cnt_a_q) ==
							    CNT_W'(MAX_TERMS)) begin
								// drop the term, remember it
								ovf_d = 1'b1;
							end else if (cmd.op == OP_INS_A && cnt_a_q == '0) begin
								we_a    = 1'b1;
								cnt_a_d = CNT_W'(1);
							end else if (cmd.op == OP_INS_B && cnt_b_q == '0) begin
								we_b    = 1'b1;
								cnt_b_d = CNT_W'(1);
							end else begin
								// start the shift walk at the tail entry
								rd_idx_d  = (cmd.op == OP_INS_B) ?
									IDX_W'(cnt_b_q - CNT_W'(1)) :
									IDX_W'(cnt_a_q - CNT_W'(1));
								rd_addr_a = rd_idx_d;
								rd_addr_b = rd_idx_d;
								state_d   = ST_INS;
							end
						end
						OP_CLEAR: begin
							cnt_a_d = '0;
							cnt_b_d = '0;
						end
						OP_SUM: begin
							ia_d    = '0;
							ib_d    = '0;
							state_d = ST_MERGE;
						end
						default: begin
						end
					endcase
				end
			end

			ST_INS: begin
				we_a    = !ins_b_q;
				we_b    = ins_b_q;
				wr_addr = rd_idx_q + IDX_W'(1);
				if (tgt_rd.expo < new_q.expo) begin
					// move the entry up one slot and keep walking down
					wr_data = tgt_rd;
					if (rd_idx_q == '0) begin
						state_d = ST_LAST;
					end else begin
						rd_idx_d  = rd_idx_q - IDX_W'(1);
						rd_addr_a = rd_idx_d;
						rd_addr_b = rd_idx_d;
					end
				end else begin
					// equal or larger exponent stays ahead of the new term
					wr_data = new_q;
					if (ins_b_q) begin
						cnt_b_d = tgt_cnt + CNT_W'(1);
					end else begin
						cnt_a_d = tgt_cnt + CNT_W'(1);
					end
					state_d = ST_IDLE;
				end
			end

			ST_LAST: begin
				we_a    = !ins_b_q;
				we_b    = ins_b_q;
				wr_addr = '0;
				wr_data = new_q;
				if (ins_b_q) begin
					cnt_b_d = tgt_cnt + CNT_W'(1);
				end else begin
					cnt_a_d = tgt_cnt + CNT_W'(1);
				end
				state_d = ST_IDLE;
			end

			ST_MERGE: begin
				// hold the heads while the output register is full
				rd_addr_a = ia_q[IDX_W-1:0];
				rd_addr_b = ib_q[IDX_W-1:0];
				if (!sum_valid_q || !sum_stall) begin
					sum_load       = 1'b1;
					sum_d.overflow = ovf_q;
					if (!a_ok && !b_ok) begin
						// both tables empty
						sum_d.last      = 1'b1;
						sum_d.empty_res = 1'b1;
						state_d         = ST_IDLE;
					end else begin
						if (take_a) begin
							sum_d.sum_coef     = {rd_a.coef[COEF_W-1], rd_a.coef};
							sum_d.sum_exponent = rd_a.expo;
							ia_d               = ia_q + CNT_W'(1);
						end else if (take_b) begin
							sum_d.sum_coef     = {rd_b.coef[COEF_W-1], rd_b.coef};
							sum_d.sum_exponent = rd_b.expo;
							ib_d               = ib_q + CNT_W'(1);
						end else begin
							sum_d.sum_coef     = {rd_a.coef[COEF_W-1], rd_a.coef} +
								{rd_b.coef[COEF_W-1], rd_b.coef};
							sum_d.sum_exponent = rd_a.expo;
							ia_d               = ia_q + CNT_W'(1);
							ib_d               = ib_q + CNT_W'(1);
						end
						sum_d.last = (ia_d >= cnt_a_q) && (ib_d >= cnt_b_q);
						rd_addr_a  = ia_d[IDX_W-1:0];
						rd_addr_b  = ib_d[IDX_W-1:0];
						if (sum_d.last) begin
							state_d = ST_IDLE;
						end
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
